### sv/tkd_pkg.sv
// Package for the touch key debouncer and press classifier.
// Holds the time width, event codes, register indexes and shared struct types.
// No dependencies.
package tkd_pkg;

   localparam int TIME_BITS = 32;
   localparam int REG_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int EVENT_BITS = 3;

   localparam logic [EVENT_BITS-1:0] EV_NONE     = 3'd0;
   localparam logic [EVENT_BITS-1:0] EV_PRESSED  = 3'd1;
   localparam logic [EVENT_BITS-1:0] EV_RELEASED = 3'd2;
   localparam logic [EVENT_BITS-1:0] EV_SHORT    = 3'd3;
   localparam logic [EVENT_BITS-1:0] EV_LONG     = 3'd4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SHORT_MIN = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SHORT_MAX = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG      = 2'd3;

   localparam logic [REG_BITS-1:0] DEBOUNCE_RESET  = 16'd20;
   localparam logic [REG_BITS-1:0] SHORT_MIN_RESET = 16'd20;
   localparam logic [REG_BITS-1:0] SHORT_MAX_RESET = 16'd1000;
   localparam logic [REG_BITS-1:0] LONG_RESET      = 16'd3000;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   typedef struct packed {
      logic [REG_BITS-1:0] debounce_ms;
      logic [REG_BITS-1:0] short_min_ms;
      logic [REG_BITS-1:0] short_max_ms;
      logic [REG_BITS-1:0] long_ms;
   } cfg_type;

   typedef struct packed {
      logic                 kind;
      logic                 pin_level;
      logic [TIME_BITS-1:0] now_ms;
   } item_type;

   typedef struct packed {
      logic [EVENT_BITS-1:0] event_code;
      logic                  pressed;
   } result_type;

endpackage

### sv/tkd_if.sv
// Valid/ready channel interfaces for the request and response words.
// Depends on tkd_pkg for the field widths.
interface tkd_req_if;
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic                          pin_level;
   logic [tkd_pkg::TIME_BITS-1:0] now_ms;

   modport source (output valid, output kind, output pin_level, output now_ms, input ready);
   modport sink (input valid, input kind, input pin_level, input now_ms, output ready);
endinterface

interface tkd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [tkd_pkg::EVENT_BITS-1:0] event_code;
   logic                           pressed;

   modport source (output valid, output event_code, output pressed, input ready);
   modport sink (input valid, input event_code, input pressed, output ready);
endinterface

### sv/tkd_classifier.sv
// Debounce and press classification state, updated on each accepted step.
// Depends on tkd_pkg for types, codes and the time width.
module tkd_classifier (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  tkd_pkg::item_type  item,
   input  tkd_pkg::cfg_type   cfg,
   output tkd_pkg::result_type result
);

   logic                               raw_level_ff, raw_level_in;
   logic                               stable_level_ff, stable_level_in;
   logic [tkd_pkg::TIME_BITS-1:0]      change_time_ff, change_time_in;
   logic [tkd_pkg::TIME_BITS-1:0]      press_time_ff, press_time_in;
   logic                               long_done_ff, long_done_in;
   logic [tkd_pkg::EVENT_BITS-1:0]     pending_ff, pending_in;

   logic [tkd_pkg::TIME_BITS-1:0] since_change;
   logic [tkd_pkg::TIME_BITS-1:0] duration;
   logic [tkd_pkg::TIME_BITS-1:0] hold;
   logic                          settled;
   logic                          press;
   logic                          release_now;
   logic                          is_short;
   logic                          long_done_mid;
   logic                          long_fire;
   logic [tkd_pkg::EVENT_BITS-1:0] sample_event;

   always_comb begin
      change_time_in = (item.pin_level != raw_level_ff) ? item.now_ms : change_time_ff;
      raw_level_in   = item.pin_level;
      since_change   = item.now_ms - change_time_in;
      settled        = (since_change >= {{(tkd_pkg::TIME_BITS-tkd_pkg::REG_BITS){1'b0}},
                                         cfg.debounce_ms})
                       && (item.pin_level != stable_level_ff);
      press          = settled && !item.pin_level;
      release_now    = settled && item.pin_level;
      stable_level_in = settled ? item.pin_level : stable_level_ff;
      duration       = item.now_ms - press_time_ff;
      is_short       = !long_done_ff
                       && (duration >= {{(tkd_pkg::TIME_BITS-tkd_pkg::REG_BITS){1'b0}},
                                        cfg.short_min_ms})
                       && (duration < {{(tkd_pkg::TIME_BITS-tkd_pkg::REG_BITS){1'b0}},
                                       cfg.short_max_ms});
      press_time_in  = press ? item.now_ms : press_time_ff;
      long_done_mid  = press ? 1'b0 : long_done_ff;
      hold           = press ? '0 : duration;
      long_fire      = !stable_level_in && !long_done_mid
                       && (hold >= {{(tkd_pkg::TIME_BITS-tkd_pkg::REG_BITS){1'b0}},
                                    cfg.long_ms});
      long_done_in   = long_done_mid || long_fire;
      if (long_fire) begin
         sample_event = tkd_pkg::EV_LONG;
      end else if (press) begin
         sample_event = tkd_pkg::EV_PRESSED;
      end else if (release_now) begin
         sample_event = is_short ? tkd_pkg::EV_SHORT : tkd_pkg::EV_RELEASED;
      end else begin
         sample_event = pending_ff;
      end
      pending_in = (item.kind == tkd_pkg::KIND_READ) ? tkd_pkg::EV_NONE : sample_event;

      if (item.kind == tkd_pkg::KIND_READ) begin
         result.event_code = pending_ff;
         result.pressed    = !stable_level_ff;
      end else begin
         result.event_code = tkd_pkg::EV_NONE;
         result.pressed    = !stable_level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_level_ff    <= 1'b1;
         stable_level_ff <= 1'b1;
         change_time_ff  <= '0;
         press_time_ff   <= '0;
         long_done_ff    <= 1'b0;
         pending_ff      <= tkd_pkg::EV_NONE;
      end else if (step) begin
         pending_ff <= pending_in;
         if (item.kind == tkd_pkg::KIND_SAMPLE) begin
            raw_level_ff    <= raw_level_in;
            stable_level_ff <= stable_level_in;
            change_time_ff  <= change_time_in;
            press_time_ff   <= press_time_in;
            long_done_ff    <= long_done_in;
         end
      end
   end

endmodule

### sv/touch_key_debounce_press_classifier_top.sv
// Top level of the touch key debouncer and press classifier.
// A request word passes through the input register, then the result register.
// Throughput: one word per cycle while rsp_ch is ready, set by this register pair.
// A full result register does not block the input register while it is empty.
// Reset is synchronous and active high; it restores the register defaults and
// clears the key state, the pending event and both valid flags.
module touch_key_debounce_press_classifier_top (
   input  logic                               clock,
   input  logic                               reset,
   tkd_req_if.sink                            req_ch,
   tkd_rsp_if.source                          rsp_ch,
   input  logic                               csr_wr_en,
   input  logic [tkd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tkd_pkg::REG_BITS-1:0]       csr_wr_data
);

   tkd_pkg::cfg_type    cfg_ff;
   tkd_pkg::item_type   item_ff;
   tkd_pkg::result_type result_ff;
   tkd_pkg::result_type result;
   logic                item_valid_ff;
   logic                result_valid_ff;
   logic                result_en;
   logic                item_en;

   assign result_en = !result_valid_ff || rsp_ch.ready;
   assign item_en   = !item_valid_ff || result_en;

   assign req_ch.ready      = item_en;
   assign rsp_ch.valid      = result_valid_ff;
   assign rsp_ch.event_code = result_ff.event_code;
   assign rsp_ch.pressed    = result_ff.pressed;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms  <= tkd_pkg::DEBOUNCE_RESET;
         cfg_ff.short_min_ms <= tkd_pkg::SHORT_MIN_RESET;
         cfg_ff.short_max_ms <= tkd_pkg::SHORT_MAX_RESET;
         cfg_ff.long_ms      <= tkd_pkg::LONG_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            tkd_pkg::CSR_DEBOUNCE:  cfg_ff.debounce_ms  <= csr_wr_data;
            tkd_pkg::CSR_SHORT_MIN: cfg_ff.short_min_ms <= csr_wr_data;
            tkd_pkg::CSR_SHORT_MAX: cfg_ff.short_max_ms <= csr_wr_data;
            tkd_pkg::CSR_LONG:      cfg_ff.long_ms      <= csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff   <= 1'b0;
         result_valid_ff <= 1'b0;
      end else begin
         if (item_en) begin
            item_valid_ff <= req_ch.valid;
         end
         if (result_en) begin
            result_valid_ff <= item_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_en && req_ch.valid) begin
         item_ff.kind      <= req_ch.kind;
         item_ff.pin_level <= req_ch.pin_level;
         item_ff.now_ms    <= req_ch.now_ms;
      end
      if (result_en && item_valid_ff) begin
         result_ff <= result;
      end
   end

   tkd_classifier u_classifier (
      .clock  (clock),
      .reset  (reset),
      .step   (item_valid_ff && result_en),
      .item   (item_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

endmodule

### sv/tkd_checker.sv
// Port-level checks for the touch key debouncer and press classifier.
// Bound to touch_key_debounce_press_classifier_top; depends on tkd_pkg.
module tkd_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [tkd_pkg::EVENT_BITS-1:0] rsp_event_code,
   input logic                           rsp_pressed
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_code) && $stable(rsp_pressed))
      else $error("Response word changed while stalled.");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Response valid right after reset.");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_event_code <= tkd_pkg::EV_LONG)
      else $error("Undefined event code on the response.");

   a_event_pressed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_code == tkd_pkg::EV_PRESSED |-> rsp_pressed
      || rsp_event_code != tkd_pkg::EV_PRESSED)
      else $error("Pressed event read while the key shows released.");

endmodule

bind touch_key_debounce_press_classifier_top tkd_checker u_tkd_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_event_code (rsp_ch.event_code),
   .rsp_pressed    (rsp_ch.pressed)
);

### tb/tb_touch_key_debounce_press_classifier_top.sv
// Testbench for the touch key debouncer and press classifier top level.
// Drives request words, writes the four threshold registers, and predicts each response word.
// Depends on tkd_pkg, tkd_req_if and tkd_rsp_if from the RTL.
module tb_touch_key_debounce_press_classifier_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD   = 80;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                               csr_wr_en;
   logic [tkd_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [tkd_pkg::REG_BITS-1:0]       csr_wr_data;

   tkd_req_if req_ch ();
   tkd_rsp_if rsp_ch ();

   touch_key_debounce_press_classifier_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   tkd_pkg::cfg_type               thresholds;
   logic                           key_raw;
   logic                           key_stable;
   logic [tkd_pkg::TIME_BITS-1:0]  change_stamp;
   logic [tkd_pkg::TIME_BITS-1:0]  press_stamp;
   logic                           long_fired;
   logic [tkd_pkg::EVENT_BITS-1:0] held_event;

   tkd_pkg::result_type           expected_words[$];
   logic [tkd_pkg::TIME_BITS-1:0] now_stamp;
   int                   words_sent;
   int                   words_checked;
   int                   settings_used;
   int                   failures;
   int                   events_read[5];
   int                   cycle_count;
   bit                   req_idle_on = 1'b1;
   bit                   rsp_idle_on = 1'b1;
   int                   hold_requests;
   int                   holds_served;
   int                   hold_left;
   int                   stall_left;

   function automatic tkd_pkg::result_type classify_word(input tkd_pkg::item_type w);
      tkd_pkg::result_type           r;
      logic [tkd_pkg::TIME_BITS-1:0] span;
      r.event_code = tkd_pkg::EV_NONE;
      if (w.kind == tkd_pkg::KIND_READ) begin
         r.event_code = held_event;
         held_event = tkd_pkg::EV_NONE;
      end else begin
         if (w.pin_level != key_raw) begin
            change_stamp = w.now_ms;
            key_raw = w.pin_level;
         end
         span = w.now_ms - change_stamp;
         if (span >= thresholds.debounce_ms && w.pin_level != key_stable) begin
            key_stable = w.pin_level;
            if (w.pin_level == 1'b0) begin
               held_event = tkd_pkg::EV_PRESSED;
               press_stamp = w.now_ms;
               long_fired = 1'b0;
            end else begin
               held_event = tkd_pkg::EV_RELEASED;
               if (!long_fired) begin
                  span = w.now_ms - press_stamp;
                  if (span >= thresholds.short_min_ms && span < thresholds.short_max_ms) begin
                     held_event = tkd_pkg::EV_SHORT;
                  end
               end
            end
         end
         span = w.now_ms - press_stamp;
         if (key_stable == 1'b0 && !long_fired && span >= thresholds.long_ms) begin
            long_fired = 1'b1;
            held_event = tkd_pkg::EV_LONG;
         end
      end
      r.pressed = (key_stable == 1'b0);
      return r;
   endfunction

   task automatic send_word(input tkd_pkg::item_type w);
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.kind      <= w.kind;
      req_ch.pin_level <= w.pin_level;
      req_ch.now_ms    <= w.now_ms;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_words.push_back(classify_word(w));
      words_sent++;
   endtask

   task automatic sample_pin(input logic level, input int unsigned dt);
      tkd_pkg::item_type w;
      now_stamp = now_stamp + dt;
      w.kind = tkd_pkg::KIND_SAMPLE;
      w.pin_level = level;
      w.now_ms = now_stamp;
      send_word(w);
   endtask

   task automatic read_event();
      tkd_pkg::item_type w;
      w.kind = tkd_pkg::KIND_READ;
      w.pin_level = 1'($urandom_range(0, 1));
      w.now_ms = $urandom();
      send_word(w);
   endtask

   task automatic maybe_read();
      if ($urandom_range(0, 2) == 0) read_event();
   endtask

   task automatic wait_for_responses();
      req_ch.valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_config(input tkd_pkg::cfg_type c);
      logic [tkd_pkg::CSR_INDEX_BITS-1:0] idx[4];
      logic [tkd_pkg::REG_BITS-1:0]       val[4];
      idx = '{tkd_pkg::CSR_DEBOUNCE, tkd_pkg::CSR_SHORT_MIN, tkd_pkg::CSR_SHORT_MAX,
              tkd_pkg::CSR_LONG};
      val = '{c.debounce_ms, c.short_min_ms, c.short_max_ms, c.long_ms};
      for (int i = 0; i < 4; i++) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= idx[i];
         csr_wr_data <= val[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      @(posedge clock);
      thresholds = c;
      settings_used++;
   endtask

   task automatic key_session();
      tkd_pkg::item_type w;
      int       hold;
      int       acc;
      int       step;
      int       n;
      if ($urandom_range(0, 7) == 0) begin
         n = $urandom_range(1, 3);
         repeat (n) begin
            w.kind = 1'($urandom_range(0, 1));
            w.pin_level = 1'($urandom_range(0, 1));
            w.now_ms = $urandom();
            now_stamp = w.now_ms;
            send_word(w);
         end
      end
      now_stamp = now_stamp + $urandom_range(1, 60);
      repeat ($urandom_range(0, 4)) sample_pin(1'($urandom_range(0, 1)), $urandom_range(0, 8));
      case ($urandom_range(0, 3))
         0: hold = $urandom_range(0, thresholds.short_min_ms);
         1: hold = $urandom_range(thresholds.short_min_ms, thresholds.short_max_ms);
         2: hold = $urandom_range(thresholds.short_max_ms, thresholds.long_ms);
         default: hold = thresholds.long_ms + $urandom_range(0, 200);
      endcase
      hold = hold + thresholds.debounce_ms;
      acc = 0;
      sample_pin(1'b0, 1);
      while (acc < hold) begin
         step = $urandom_range(1, hold / 3 + 1);
         acc = acc + step;
         sample_pin(1'b0, step);
         maybe_read();
      end
      repeat ($urandom_range(0, 3)) sample_pin(1'($urandom_range(0, 1)), $urandom_range(0, 8));
      acc = 0;
      sample_pin(1'b1, 1);
      while (acc < thresholds.debounce_ms + 1) begin
         step = $urandom_range(1, thresholds.debounce_ms / 2 + 1);
         acc = acc + step;
         sample_pin(1'b1, step);
         maybe_read();
      end
      read_event();
   endtask

   task automatic run_sessions(input int budget);
      int target;
      target = words_sent + budget;
      while (words_sent < target) key_session();
   endtask

   task automatic test_default_press();
      read_event();
      sample_pin(1'b0, 0);
      sample_pin(1'b1, 5);
      sample_pin(1'b0, 3);
      sample_pin(1'b0, 25);
      read_event();
      sample_pin(1'b1, 100);
      sample_pin(1'b1, 20);
      read_event();
      read_event();
   endtask

   task automatic test_long_and_overwrite();
      sample_pin(1'b0, 10);
      sample_pin(1'b0, 20);
      sample_pin(1'b0, 3000);
      read_event();
      sample_pin(1'b1, 1);
      sample_pin(1'b1, 20);
      read_event();
   endtask

   task automatic test_zero_thresholds();
      wait_for_responses();
      write_config('{debounce_ms: 16'd0, short_min_ms: 16'd0, short_max_ms: 16'd0,
                     long_ms: 16'd0});
      sample_pin(1'b0, 1);
      read_event();
      sample_pin(1'b1, 1);
      read_event();
      wait_for_responses();
      write_config('{debounce_ms: 16'd0, short_min_ms: 16'd5, short_max_ms: 16'd5,
                     long_ms: 16'hFFFF});
      sample_pin(1'b0, 1);
      sample_pin(1'b1, 7);
      read_event();
   endtask

   task automatic test_extremes();
      wait_for_responses();
      write_config('{debounce_ms: 16'hFFFF, short_min_ms: 16'hFFFF, short_max_ms: 16'hFFFF,
                     long_ms: 16'hFFFF});
      now_stamp = 32'hFFFF_FFF0;
      sample_pin(1'b0, 0);
      sample_pin(1'b0, 32'hFFFF);
      read_event();
      sample_pin(1'b1, 100);
      sample_pin(1'b1, 32'hFFFF);
      read_event();
      now_stamp = 32'h0000_0000;
      sample_pin(1'b1, 0);
   endtask

   task automatic test_random_settings();
      tkd_pkg::cfg_type c;
      for (int s = 0; s < 4; s++) begin
         wait_for_responses();
         if (s == 0) begin
            c = '{tkd_pkg::DEBOUNCE_RESET, tkd_pkg::SHORT_MIN_RESET, tkd_pkg::SHORT_MAX_RESET,
                  tkd_pkg::LONG_RESET};
         end else begin
            c.debounce_ms  = 16'($urandom_range(0, 40));
            c.short_min_ms = 16'($urandom_range(0, 150));
            c.short_max_ms = 16'($urandom_range(0, 500));
            c.long_ms      = 16'($urandom_range(0, 900));
         end
         write_config(c);
         run_sessions(100);
      end
   endtask

   task automatic test_backpressure();
      wait_for_responses();
      req_idle_on = 1'b0;
      hold_requests <= hold_requests + 1;
      run_sessions(24);
      wait_for_responses();
      req_idle_on = 1'b1;
   endtask

   task automatic test_quiet_tail();
      wait_for_responses();
      req_idle_on = 1'b0;
      rsp_idle_on <= 1'b0;
      write_config('{debounce_ms: 16'd15, short_min_ms: 16'd30, short_max_ms: 16'd300,
                     long_ms: 16'd600});
      run_sessions(60);
   endtask

   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      tkd_pkg::result_type exp_word;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_words.size() == 0) begin
            $error("unexpected response word: event_code %0d, pressed %0d",
                   rsp_ch.event_code, rsp_ch.pressed);
            failures++;
         end else begin
            exp_word = expected_words.pop_front();
            words_checked++;
            if (rsp_ch.event_code !== exp_word.event_code) begin
               $error("event_code mismatch: expected %0d, actual %0d",
                      exp_word.event_code, rsp_ch.event_code);
               failures++;
            end
            if (rsp_ch.pressed !== exp_word.pressed) begin
               $error("pressed mismatch: expected %0d, actual %0d",
                      exp_word.pressed, rsp_ch.pressed);
               failures++;
            end
            if (exp_word.event_code <= tkd_pkg::EV_LONG) events_read[exp_word.event_code]++;
         end
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("touch_key_debounce_press_classifier_top test failed");
      $finish;
   end

   initial begin
      req_ch.valid     <= 1'b0;
      req_ch.kind      <= tkd_pkg::KIND_SAMPLE;
      req_ch.pin_level <= 1'b1;
      req_ch.now_ms    <= '0;
      csr_wr_en        <= 1'b0;
      csr_index        <= tkd_pkg::CSR_DEBOUNCE;
      csr_wr_data      <= '0;
      thresholds   = '{tkd_pkg::DEBOUNCE_RESET, tkd_pkg::SHORT_MIN_RESET,
                       tkd_pkg::SHORT_MAX_RESET, tkd_pkg::LONG_RESET};
      key_raw      = 1'b1;
      key_stable   = 1'b1;
      change_stamp = '0;
      press_stamp  = '0;
      long_fired   = 1'b0;
      held_event   = tkd_pkg::EV_NONE;
      now_stamp    = 32'd1000;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_default_press();
      test_long_and_overwrite();
      test_zero_thresholds();
      test_extremes();
      test_random_settings();
      test_backpressure();
      test_quiet_tail();

      wait_for_responses();
      repeat (8) @(posedge clock);
      if (expected_words.size() != 0) failures++;
      $display("Sent %0d request words over %0d threshold settings; %0d response words checked.",
               words_sent, settings_used, words_checked);
      $display("Events read back: none %0d, pressed %0d, released %0d, short %0d, long %0d.",
               events_read[0], events_read[1], events_read[2], events_read[3],
               events_read[4]);
      if (failures == 0) begin
         $display("touch_key_debounce_press_classifier_top test passed");
      end else begin
         $display("touch_key_debounce_press_classifier_top test failed");
      end
      $finish;
   end

endmodule

### touch_key_debounce_press_classifier_top.f
sv/tkd_pkg.sv
sv/tkd_if.sv
sv/tkd_classifier.sv
sv/touch_key_debounce_press_classifier_top.sv
sv/tkd_checker.sv
tb/tb_touch_key_debounce_press_classifier_top.sv
